// File: design/dtpb_pkg.sv
// shared types and constants of the depth to point back-projection unit
`default_nettype none

package dtpb_pkg;

	localparam int POS_W      = 12;
	localparam int SIZE_W     = 13;
	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int CENTER_W   = 16;
	localparam int RECIP_W    = 24;
	localparam int COORD_W    = 32;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_CENTER_X        = 3'd2,
		REG_CENTER_Y        = 3'd3,
		REG_INV_FOCAL_X     = 3'd4,
		REG_INV_FOCAL_Y     = 3'd5,
		REG_INV_DEPTH_SCALE = 3'd6
	} reg_index_t;

	// one pixel with a valid depth, waiting for the arithmetic
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} qent_t;

	// camera intrinsics seen by the arithmetic
	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [RECIP_W-1:0]  inv_focal_x;
		logic [RECIP_W-1:0]  inv_focal_y;
		logic [RECIP_W-1:0]  inv_depth_scale;
	} cam_cfg_t;

endpackage

`default_nettype wire

// File: design/dtpb_front.sv
// raster position tracking and zero-depth filtering of incoming pixels
`default_nettype none

module dtpb_front #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pixel_valid,
	output logic                              pixel_ready,
	input  wire logic [15:0]                  depth_sample,
	input  wire logic [7:0]                   blue,
	input  wire logic [7:0]                   green,
	input  wire logic [7:0]                   red,
	input  wire logic                         frame_start,
	input  wire logic [12:0]                  image_width,
	input  wire logic [12:0]                  image_height,
	output logic                              push,
	output dtpb_pkg::qent_t                   push_data,
	input  wire logic                         full
);
	import dtpb_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_COLS);
	localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_ROWS);

	logic [COL_W-1:0]  col_q, col_cur, col_nxt;
	logic [ROW_W-1:0]  row_q, row_cur, row_nxt;
	logic [SIZE_W-1:0] w_eff, h_eff, col_inc, row_inc;
	logic              accept;

	always_comb begin
		if (image_width == '0) begin
			w_eff = SIZE_W'(1);
		end else if (image_width > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = image_width;
		end
		if (image_height == '0) begin
			h_eff = SIZE_W'(1);
		end else if (image_height > MAX_H) begin
			h_eff = MAX_H;
		end else begin
			h_eff = image_height;
		end
	end

	// frame start puts this pixel at the origin
	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;
	assign col_inc = SIZE_W'(col_cur) + SIZE_W'(1);
	assign row_inc = SIZE_W'(row_cur) + SIZE_W'(1);

	always_comb begin
		col_nxt = col_inc[COL_W-1:0];
		row_nxt = row_cur;
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
		end
	end

	assign pixel_ready = !full;
	assign accept      = pixel_valid && pixel_ready;
	assign push        = accept && (depth_sample != '0);

	always_comb begin
		push_data.depth = depth_sample;
		push_data.col   = POS_W'(col_cur);
		push_data.row   = POS_W'(row_cur);
		push_data.blue  = blue;
		push_data.green = green;
		push_data.red   = red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

`default_nettype wire

// File: design/dtpb_queue.sv
// short first-in first-out queue between the front and the arithmetic
`default_nettype none

module dtpb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dtpb_pkg::qent_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output dtpb_pkg::qent_t      pop_data,
	output logic                 empty
);
	import dtpb_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t             store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/dtpb_back.sv
// pipelined back-projection arithmetic with output register
`default_nettype none

module dtpb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtpb_pkg::cam_cfg_t cfg,
	input  wire logic              empty,
	input  wire dtpb_pkg::qent_t   head,
	output logic                   pop,
	output logic                   point_valid,
	input  wire logic              point_ready,
	output logic signed [31:0]     point_x,
	output logic signed [31:0]     point_y,
	output logic [31:0]            point_z,
	output logic [7:0]             point_blue,
	output logic [7:0]             point_green,
	output logic [7:0]             point_red
);
	import dtpb_pkg::*;

	localparam int ZF_W  = DEPTH_W + RECIP_W;
	localparam int MAG_W = CENTER_W + COORD_W;
	localparam int PP_W  = (MAG_W - RECIP_W) + RECIP_W;

	// rounding, sign and saturation of one coordinate
	function automatic logic [COORD_W-1:0] finish(input logic [PP_W-1:0] a,
	                                              input logic [PP_W:0] b,
	                                              input logic neg);
		logic [PP_W:0]   sum;
		logic [PP_W-4:0] r;
		logic [COORD_W-1:0] res;
		sum = (PP_W+1)'(a) + (b >> RECIP_W);
		r   = sum[PP_W:4];
		if (neg) begin
			if (r >= (PP_W-3)'(33'h080000000)) begin
				res = 32'h8000_0000;
			end else begin
				res = 32'd0 - r[COORD_W-1:0];
			end
		end else if (r > (PP_W-3)'(33'h07FFFFFFF)) begin
			res = 32'h7FFF_FFFF;
		end else begin
			res = r[COORD_W-1:0];
		end
		return res;
	endfunction

	logic advance;

	logic                 v_s1, v_s2, v_s3;
	logic [ZF_W-1:0]      zf_s1;
	logic [CENTER_W-1:0]  off_x_s1, off_y_s1;
	logic                 neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [COLOR_W-1:0]   b_s1, g_s1, r_s1, b_s2, g_s2, r_s2, b_s3, g_s3, r_s3;
	logic [COORD_W-1:0]   z_s2, z_s3;
	logic [MAG_W-1:0]     mag_x_s2, mag_y_s2;
	logic [PP_W-1:0]      ax_s3, ay_s3;
	logic [PP_W:0]        bx_s3, by_s3;

	logic [CENTER_W-1:0]  px16, py16;
	logic                 neg_x, neg_y;
	logic [CENTER_W-1:0]  off_x, off_y;
	logic [COORD_W-1:0]   z_val;

	assign advance = !point_valid || point_ready;
	assign pop     = advance && !empty;

	// offset from the principal point in Q.4, as sign and magnitude
	always_comb begin
		px16  = {head.col, 4'b0000};
		py16  = {head.row, 4'b0000};
		neg_x = cfg.center_x > px16;
		neg_y = cfg.center_y > py16;
		off_x = neg_x ? cfg.center_x - px16 : px16 - cfg.center_x;
		off_y = neg_y ? cfg.center_y - py16 : py16 - cfg.center_y;
	end

	// depth in Q16.16, rounded
	assign z_val = COORD_W'((zf_s1 + ZF_W'(128)) >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			point_valid <= 1'b0;
		end else if (advance) begin
			v_s1        <= !empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			point_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zf_s1    <= ZF_W'(head.depth) * ZF_W'(cfg.inv_depth_scale);
			off_x_s1 <= off_x;
			off_y_s1 <= off_y;
			neg_x_s1 <= neg_x;
			neg_y_s1 <= neg_y;
			b_s1     <= head.blue;
			g_s1     <= head.green;
			r_s1     <= head.red;

			z_s2     <= z_val;
			mag_x_s2 <= MAG_W'(off_x_s1) * MAG_W'(z_val);
			mag_y_s2 <= MAG_W'(off_y_s1) * MAG_W'(z_val);
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			b_s2     <= b_s1;
			g_s2     <= g_s1;
			r_s2     <= r_s1;

			// magnitude times reciprocal, split into high and low partial products
			ax_s3    <= PP_W'(mag_x_s2[MAG_W-1:RECIP_W]) * PP_W'(cfg.inv_focal_x);
			ay_s3    <= PP_W'(mag_y_s2[MAG_W-1:RECIP_W]) * PP_W'(cfg.inv_focal_y);
			bx_s3    <= (PP_W+1)'(PP_W'(mag_x_s2[RECIP_W-1:0]) * PP_W'(cfg.inv_focal_x))
			            + ((PP_W+1)'(1) << 27);
			by_s3    <= (PP_W+1)'(PP_W'(mag_y_s2[RECIP_W-1:0]) * PP_W'(cfg.inv_focal_y))
			            + ((PP_W+1)'(1) << 27);
			z_s3     <= z_s2;
			neg_x_s3 <= neg_x_s2;
			neg_y_s3 <= neg_y_s2;
			b_s3     <= b_s2;
			g_s3     <= g_s2;
			r_s3     <= r_s2;

			point_x     <= finish(ax_s3, bx_s3, neg_x_s3);
			point_y     <= finish(ay_s3, by_s3, neg_y_s3);
			point_z     <= z_s3;
			point_blue  <= b_s3;
			point_green <= g_s3;
			point_red   <= r_s3;
		end
	end

endmodule

`default_nettype wire

// File: design/depth_to_point_backprojection_unit.sv
// top level of the depth to point back-projection unit
`default_nettype none

// Turns a registered depth + BGR pixel stream, in raster order, into coloured
// 3D points by pinhole back-projection: z = d*inv_depth_scale,
// x = (col-center_x)*z*inv_focal_x, y = (row-center_y)*z*inv_focal_y, all in
// Q16.16, x and y saturated. Pixels with zero depth give no point but still
// advance the raster position; frame_start puts a pixel at column 0, row 0.
// One pixel is taken per clock while the output side keeps up, and a point
// passes through the four-entry queue, then three multiplier stages (depth
// scale, offset times depth, reciprocal as two partial products) and the
// output register. The queue lets the pixel side keep going while the point
// side is stalled, until the queue is full. Intrinsics and image size sit in
// an APB register file, one 32-bit word per register from address 0; write
// them only while idle.
module depth_to_point_backprojection_unit #(
	parameter int MAX_COLS = 4096,
	parameter int MAX_ROWS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// apb register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// pixel channel
	input  wire logic               pixel_valid,
	output logic                    pixel_ready,
	input  wire logic [15:0]        depth_sample,
	input  wire logic [7:0]         blue,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         red,
	input  wire logic               frame_start,
	// point channel
	output logic                    point_valid,
	input  wire logic               point_ready,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic [31:0]             point_z,
	output logic [7:0]              point_blue,
	output logic [7:0]              point_green,
	output logic [7:0]              point_red
);
	import dtpb_pkg::*;

	// register file
	logic [SIZE_W-1:0]   image_width_q, image_height_q;
	logic [CENTER_W-1:0] center_x_q, center_y_q;
	logic [RECIP_W-1:0]  inv_focal_x_q, inv_focal_y_q, inv_depth_scale_q;

	reg_index_t reg_idx;
	logic       wr_en;
	cam_cfg_t   cfg;

	logic   push, full, pop, empty;
	qent_t  push_data, head;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[4:2]);
	// a register is written in the access phase of a write transfer
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= SIZE_W'(640);
			image_height_q    <= SIZE_W'(480);
			center_x_q        <= CENTER_W'(5120);
			center_y_q        <= CENTER_W'(3840);
			inv_focal_x_q     <= RECIP_W'(32264);
			inv_focal_y_q     <= RECIP_W'(32264);
			inv_depth_scale_q <= RECIP_W'(16777);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:     image_width_q     <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= pwdata[SIZE_W-1:0];
				REG_CENTER_X:        center_x_q        <= pwdata[CENTER_W-1:0];
				REG_CENTER_Y:        center_y_q        <= pwdata[CENTER_W-1:0];
				REG_INV_FOCAL_X:     inv_focal_x_q     <= pwdata[RECIP_W-1:0];
				REG_INV_FOCAL_Y:     inv_focal_y_q     <= pwdata[RECIP_W-1:0];
				REG_INV_DEPTH_SCALE: inv_depth_scale_q <= pwdata[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unused addresses read as zero
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:     prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT:    prdata = 32'(image_height_q);
			REG_CENTER_X:        prdata = 32'(center_x_q);
			REG_CENTER_Y:        prdata = 32'(center_y_q);
			REG_INV_FOCAL_X:     prdata = 32'(inv_focal_x_q);
			REG_INV_FOCAL_Y:     prdata = 32'(inv_focal_y_q);
			REG_INV_DEPTH_SCALE: prdata = 32'(inv_depth_scale_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		cfg.center_x        = center_x_q;
		cfg.center_y        = center_y_q;
		cfg.inv_focal_x     = inv_focal_x_q;
		cfg.inv_focal_y     = inv_focal_y_q;
		cfg.inv_depth_scale = inv_depth_scale_q;
	end

	// front: raster counters, drops pixels without depth
	dtpb_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.depth_sample (depth_sample),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.frame_start  (frame_start),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.push         (push),
		.push_data    (push_data),
		.full         (full)
	);

	// decoupling queue
	dtpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	// back: fixed-point projection and output register
	dtpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.point_blue  (point_blue),
		.point_green (point_green),
		.point_red   (point_red)
	);

endmodule

`default_nettype wire
